>>> rtl/core/tsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsr_pkg
// Shared types and constants for the thread scheduler / rendezvous block.
// ----------------------------------------------------------------------------
package tsr_pkg;

    localparam int THREAD_SLOTS = 16;
    localparam int IDX_W        = $clog2(THREAD_SLOTS);
    localparam int CNT_W        = $clog2(THREAD_SLOTS + 1);
    localparam int SUM_W        = IDX_W + 1;

    localparam int OP_W   = 3;
    localparam int PEER_W = 5;
    localparam int LEN_W  = 32;
    localparam int IN_W   = 40;
    localparam int OUT_W  = 48;

    // partner codes held in a blocked slot
    localparam logic [PEER_W-1:0] PARTNER_ANY  = 5'd16;
    localparam logic [PEER_W-1:0] PARTNER_UART = 5'd31;
    localparam logic [PEER_W-1:0] PEER_LIMIT   = 5'd16;

    typedef enum logic [1:0] {
        ST_FREE    = 2'd0,
        ST_READY   = 2'd1,
        ST_RUNNING = 2'd2,
        ST_BLOCKED = 2'd3
    } slot_state_t;

    typedef enum logic [OP_W-1:0] {
        OP_CREATE = 3'd0,
        OP_EXIT   = 3'd1,
        OP_SCHED  = 3'd2,
        OP_SEND   = 3'd3,
        OP_RECV   = 3'd4,
        OP_UART   = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        STAT_DONE    = 2'd0,
        STAT_ERROR   = 2'd1,
        STAT_BLOCKED = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_PEER,
        S_SCAN,
        S_PICK_OLD,
        S_PICK_NEW,
        S_DONE
    } fsm_t;

    typedef enum logic [1:0] {
        SCAN_FREE,
        SCAN_READY,
        SCAN_RECV
    } scan_kind_t;

    typedef struct packed {
        slot_state_t        slot_st;
        logic [PEER_W-1:0]  partner;
        logic [LEN_W-1:0]   length;
    } entry_t;

    localparam int ENT_W = $bits(entry_t);

endpackage

>>> rtl/core/thread_scheduler_ipc_rendezvous.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thread_scheduler_ipc_rendezvous
// Hardware thread table with round-robin scheduling and rendezvous messaging.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_*): one kernel operation per item (create, exit,
//   schedule, send, receive, block on UART). Result channel (m_*): exactly
//   one result item per input item, in order.
//   The slot table (state, wait partner, wait length) sits in one RAM with a
//   registered read; a sequencer reads, modifies and writes it back
//   one entry per cycle. Per-slot valid flops make untouched entries read as
//   their reset value, so no clearing pass is needed after reset.
// Steps from accept to result loaded, each ending in the done state; the cost
// is set by the slot scans, one RAM read per slot per cycle:
//   unknown operation, refused caller or bad peer index: check; free peer or
//   wake of a named blocked partner: check, peer read; create or wake from a
//   receive on any thread: check, slot scan; exit / schedule / block on UART:
//   check, ready scan, on a hit pick old and new; blocking send or named receive:
//   as exit after peer read; blocking any-thread receive: receive scan, then as exit.
// Throughput: one item in flight; the next item is taken the cycle after the
//   previous result is loaded into the output register, even if that result
//   is still stalled.
// Reset: slot 0 running, all other slots free, current thread 0.
// Stall: a held result keeps m_tdata stable; the sequencer waits in its
//   final state until the output register is free.
// ----------------------------------------------------------------------------
module thread_scheduler_ipc_rendezvous (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [2:0] operation, [7:3] peer, [39:8] length
    input  logic [tsr_pkg::IN_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [1:0] status, [33:2] result_value, [34] woken_valid, [38:35] woken_thread,
    // [42:39] running_thread, [43] switched, [44] idle, [47:45] zero
    output logic [tsr_pkg::OUT_W-1:0] m_tdata
);

    import tsr_pkg::*;

    // ---------------------------------------------------------------- state
    fsm_t               fsm_reg, fsm_next;
    logic [OP_W-1:0]    op_reg, op_next;
    logic [PEER_W-1:0]  peer_reg, peer_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [IDX_W-1:0]   cur_reg, cur_next;
    logic [IDX_W-1:0]   before_reg, before_next;
    slot_state_t        cur_st_reg, cur_st_next;     // cached state of current slot
    scan_kind_t         scan_kind_reg, scan_kind_next;
    logic [CNT_W-1:0]   scan_cnt_reg, scan_cnt_next; // next scan offset to issue
    logic               scan_pend_reg, scan_pend_next;
    logic [IDX_W-1:0]   pick_idx_reg, pick_idx_next;
    logic [IDX_W-1:0]   rd_idx_reg;                  // address of data on read port
    logic [THREAD_SLOTS-1:0] valid_reg;

    status_t            st_reg, st_next;
    logic [LEN_W-1:0]   val_reg, val_next;
    logic               wv_reg, wv_next;
    logic [IDX_W-1:0]   wt_reg, wt_next;

    logic               m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]   m_tdata_reg, m_tdata_next;

    // ------------------------------------------------------------------ RAM
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    entry_t             ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENT_W-1:0]   ram_rdata;

    tsr_ram #(
        .WIDTH (ENT_W),
        .DEPTH (THREAD_SLOTS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // never-written slots read as reset value: slot 0 running, rest free
    entry_t ent;
    entry_t ent_reset;
    always_comb begin
        ent_reset         = '0;
        ent_reset.slot_st = (rd_idx_reg == '0) ? ST_RUNNING : ST_FREE;
        ent = valid_reg[rd_idx_reg] ? entry_t'(ram_rdata) : ent_reset;
    end

    // --------------------------------------------------------------- decode
    logic               accept;
    logic               out_free;
    logic               op_known;
    logic               needs_run;
    logic               caller_bad;
    logic               peer_any;
    logic [IDX_W-1:0]   peer_idx;
    logic               peer_pre_ok;
    logic               partner_is_cur;
    logic               peer_match;
    logic [LEN_W-1:0]   xfer_len;

    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign op_known  = op_reg inside {[OP_CREATE:OP_UART]};
    assign needs_run = op_reg inside {OP_EXIT, OP_SEND, OP_RECV, OP_UART};
    assign caller_bad = needs_run && (ent.slot_st != ST_RUNNING);
    assign peer_any  = peer_reg == PARTNER_ANY;
    assign peer_idx  = IDX_W'(peer_reg);
    assign peer_pre_ok = (peer_reg < PEER_LIMIT)
                      && (32'(peer_reg) < THREAD_SLOTS)
                      && (peer_idx != cur_reg);
    assign partner_is_cur = 32'(ent.partner) == 32'(cur_reg);
    // send also matches a receiver waiting on any thread
    assign peer_match = (ent.slot_st == ST_BLOCKED)
                     && (partner_is_cur || ((op_reg == OP_SEND) && (ent.partner == PARTNER_ANY)));
    assign xfer_len = (len_reg < ent.length) ? len_reg : ent.length;

    // ----------------------------------------------------------------- scan
    logic [CNT_W-1:0]   scan_last;
    logic [IDX_W-1:0]   scan_base;
    logic [SUM_W-1:0]   scan_sum;
    logic [IDX_W-1:0]   scan_addr;
    logic               scan_more;
    logic               scan_cond;
    logic               scan_hit;

    assign scan_last = (scan_kind_reg == SCAN_READY) ? CNT_W'(THREAD_SLOTS)
                                                     : CNT_W'(THREAD_SLOTS - 1);
    assign scan_base = (scan_kind_reg == SCAN_READY) ? cur_reg : '0;
    assign scan_sum  = SUM_W'(scan_base) + SUM_W'(scan_cnt_reg);
    assign scan_addr = (scan_sum >= SUM_W'(THREAD_SLOTS))
                     ? IDX_W'(scan_sum - SUM_W'(THREAD_SLOTS)) : IDX_W'(scan_sum);
    assign scan_more = scan_cnt_reg <= scan_last;

    always_comb begin
        case (scan_kind_reg)
            SCAN_FREE:  scan_cond = ent.slot_st == ST_FREE;
            SCAN_READY: scan_cond = (ent.slot_st == ST_READY) && (rd_idx_reg != '0);
            SCAN_RECV:  scan_cond = (ent.slot_st == ST_BLOCKED) && partner_is_cur;
            default:    scan_cond = 1'b0;
        endcase
    end

    assign scan_hit = scan_pend_reg && scan_cond;

    // ----------------------------------------------------------- next state
    always_comb begin
        fsm_next = fsm_reg;
        case (fsm_reg)
            S_IDLE: begin
                if (accept) begin
                    fsm_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!op_known || caller_bad) begin
                    fsm_next = S_DONE;
                end else if (op_reg == OP_SEND || (op_reg == OP_RECV && !peer_any)) begin
                    fsm_next = peer_pre_ok ? S_PEER : S_DONE;
                end else begin
                    fsm_next = S_SCAN;
                end
            end
            S_PEER: begin
                if (ent.slot_st == ST_FREE || peer_match) begin
                    fsm_next = S_DONE;
                end else begin
                    fsm_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_hit) begin
                    fsm_next = (scan_kind_reg == SCAN_READY) ? S_PICK_OLD : S_DONE;
                end else if (!scan_more) begin
                    fsm_next = (scan_kind_reg == SCAN_RECV) ? S_SCAN : S_DONE;
                end
            end
            S_PICK_OLD: fsm_next = S_PICK_NEW;
            S_PICK_NEW: fsm_next = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    fsm_next = S_IDLE;
                end
            end
            default: fsm_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------- datapath
    always_comb begin
        op_next        = op_reg;
        peer_next      = peer_reg;
        len_next       = len_reg;
        cur_next       = cur_reg;
        before_next    = before_reg;
        cur_st_next    = cur_st_reg;
        scan_kind_next = scan_kind_reg;
        scan_cnt_next  = scan_cnt_reg;
        scan_pend_next = 1'b0;
        pick_idx_next  = pick_idx_reg;
        st_next        = st_reg;
        val_next       = val_reg;
        wv_next        = wv_reg;
        wt_next        = wt_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        ram_we         = 1'b0;
        ram_waddr      = cur_reg;
        ram_wdata      = '0;
        ram_raddr      = cur_reg;

        case (fsm_reg)
            S_IDLE: begin
                if (accept) begin
                    op_next     = s_tdata[2:0];
                    peer_next   = s_tdata[7:3];
                    len_next    = s_tdata[39:8];
                    before_next = cur_reg;
                    st_next     = STAT_DONE;
                    val_next    = '0;
                    wv_next     = 1'b0;
                    wt_next     = '0;
                end
            end
            S_CHECK: begin
                cur_st_next   = ent.slot_st;
                scan_cnt_next = CNT_W'(1);
                if (!op_known) begin
                    // reserved codes: no effect
                end else if (op_reg == OP_CREATE) begin
                    scan_kind_next = SCAN_FREE;
                end else if (op_reg == OP_SCHED) begin
                    scan_kind_next = SCAN_READY;
                end else if (caller_bad) begin
                    st_next = STAT_ERROR;
                end else if (op_reg == OP_EXIT) begin
                    ram_we         = 1'b1;
                    ram_wdata.slot_st = ST_FREE;
                    cur_st_next    = ST_FREE;
                    scan_kind_next = SCAN_READY;
                end else if (op_reg == OP_UART) begin
                    ram_we            = 1'b1;
                    ram_wdata.slot_st = ST_BLOCKED;
                    ram_wdata.partner = PARTNER_UART;
                    ram_wdata.length  = len_reg;
                    cur_st_next       = ST_BLOCKED;
                    st_next           = STAT_BLOCKED;
                    scan_kind_next    = SCAN_READY;
                end else if (op_reg == OP_RECV && peer_any) begin
                    scan_kind_next = SCAN_RECV;
                end else if (peer_pre_ok) begin
                    ram_raddr = peer_idx;
                end else begin
                    st_next = STAT_ERROR;
                end
            end
            S_PEER: begin
                if (ent.slot_st == ST_FREE) begin
                    st_next = STAT_ERROR;
                end else if (peer_match) begin
                    ram_we            = 1'b1;
                    ram_waddr         = rd_idx_reg;
                    ram_wdata.slot_st = ST_READY;
                    val_next          = xfer_len;
                    wv_next           = 1'b1;
                    wt_next           = rd_idx_reg;
                end else begin
                    ram_we            = 1'b1;
                    ram_wdata.slot_st = ST_BLOCKED;
                    ram_wdata.partner = peer_reg;
                    ram_wdata.length  = len_reg;
                    cur_st_next       = ST_BLOCKED;
                    st_next           = STAT_BLOCKED;
                    scan_kind_next    = SCAN_READY;
                    scan_cnt_next     = CNT_W'(1);
                end
            end
            S_SCAN: begin
                if (scan_hit) begin
                    case (scan_kind_reg)
                        SCAN_FREE: begin
                            ram_we            = 1'b1;
                            ram_waddr         = rd_idx_reg;
                            ram_wdata.slot_st = ST_READY;
                            val_next          = LEN_W'(rd_idx_reg);
                            if (rd_idx_reg == cur_reg) begin
                                cur_st_next = ST_READY;
                            end
                        end
                        SCAN_RECV: begin
                            ram_we            = 1'b1;
                            ram_waddr         = rd_idx_reg;
                            ram_wdata.slot_st = ST_READY;
                            val_next          = xfer_len;
                            wv_next           = 1'b1;
                            wt_next           = rd_idx_reg;
                        end
                        default: begin
                            pick_idx_next = rd_idx_reg;
                        end
                    endcase
                end else if (scan_more) begin
                    ram_raddr      = scan_addr;
                    scan_cnt_next  = scan_cnt_reg + CNT_W'(1);
                    scan_pend_next = 1'b1;
                end else begin
                    case (scan_kind_reg)
                        SCAN_FREE: st_next = STAT_ERROR;
                        SCAN_RECV: begin
                            // nobody waiting: block on any thread, then reschedule
                            ram_we            = 1'b1;
                            ram_wdata.slot_st = ST_BLOCKED;
                            ram_wdata.partner = PARTNER_ANY;
                            ram_wdata.length  = len_reg;
                            cur_st_next       = ST_BLOCKED;
                            st_next           = STAT_BLOCKED;
                            scan_kind_next    = SCAN_READY;
                            scan_cnt_next     = CNT_W'(1);
                        end
                        default: begin
                            // nothing ready: current stays
                        end
                    endcase
                end
            end
            S_PICK_OLD: begin
                if (cur_st_reg == ST_RUNNING) begin
                    ram_we            = 1'b1;
                    ram_wdata.slot_st = ST_READY;
                end
            end
            S_PICK_NEW: begin
                ram_we            = 1'b1;
                ram_waddr         = pick_idx_reg;
                ram_wdata.slot_st = ST_RUNNING;
                cur_next          = pick_idx_reg;
                cur_st_next       = ST_RUNNING;
            end
            S_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'b000,
                                     cur_st_reg != ST_RUNNING,
                                     cur_reg != before_reg,
                                     4'(cur_reg),
                                     4'(wt_reg),
                                     wv_reg,
                                     val_reg,
                                     st_reg};
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------ registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg       <= S_IDLE;
            cur_reg       <= '0;
            cur_st_reg    <= ST_RUNNING;
            scan_pend_reg <= 1'b0;
            valid_reg     <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            fsm_reg       <= fsm_next;
            cur_reg       <= cur_next;
            cur_st_reg    <= cur_st_next;
            scan_pend_reg <= scan_pend_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (ram_we) begin
                valid_reg[ram_waddr] <= 1'b1;
            end
        end
        op_reg         <= op_next;
        peer_reg       <= peer_next;
        len_reg        <= len_next;
        before_reg     <= before_next;
        scan_kind_reg  <= scan_kind_next;
        scan_cnt_reg   <= scan_cnt_next;
        pick_idx_reg   <= pick_idx_next;
        rd_idx_reg     <= ram_raddr;
        st_reg         <= st_next;
        val_reg        <= val_next;
        wv_reg         <= wv_next;
        wt_reg         <= wt_next;
        m_tdata_reg    <= m_tdata_next;
    end

    assign s_tready = fsm_reg == S_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ----------------------------------------------------------- assertions
    // a wake only comes with a completed rendezvous
    a_wake_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_tdata_reg[34] |-> m_tdata_reg[1:0] == STAT_DONE)
        else $error("woken partner reported without done status");

    // a switch always lands on a running thread
    a_switch_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_tdata_reg[43] |-> !m_tdata_reg[44])
        else $error("switched to a thread that is not running");

    // only the pick step marks a slot running
    a_run_write: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we && ram_wdata.slot_st == ST_RUNNING |-> fsm_reg == S_PICK_NEW)
        else $error("slot marked running outside the pick step");

    // a new result is only produced from the final sequencer state
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(fsm_reg) == S_DONE)
        else $error("result loaded outside the final state");

endmodule

>>> rtl/core/tsr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsr_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> test/thread_scheduler_ipc_rendezvous_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thread_scheduler_ipc_rendezvous_test
// Self-checking bench for the hardware thread table and rendezvous logic.
// A local model of the thread table predicts the outcome of every kernel
// call; each result item is compared field by field, in order. Directed
// calls cover the error, wake, block and idle paths; a table fill runs under
// one long output hold; biased random traffic idles both channels at random.
// ----------------------------------------------------------------------------
module thread_scheduler_ipc_rendezvous_test;
    import tsr_pkg::*;

    localparam int WATCHDOG_CYCLES = 4000;  // quiet cycles before giving up
    localparam int HOLD_CYCLES     = 300;   // long output hold-off
    localparam int END_SETTLE      = 40;    // settle after the last call, above the worst call latency

    // unused operation codes, answered as no-ops
    localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;

    // result item layout, lowest field last
    typedef struct packed {
        logic [2:0]  pad;
        logic        idle;
        logic        switched;
        logic [3:0]  running_thread;
        logic [3:0]  woken_thread;
        logic        woken_valid;
        logic [31:0] value;
        status_t     status;
    } call_outcome_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    // [2:0] operation, [7:3] peer, [39:8] length
    logic [IN_W-1:0]   s_tdata  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    // [1:0] status, [33:2] result_value, [34] woken_valid, [38:35] woken_thread,
    // [42:39] running_thread, [43] switched, [44] idle, [47:45] zero
    logic [OUT_W-1:0]  m_tdata;

    thread_scheduler_ipc_rendezvous uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Local copy of the thread table
    // ------------------------------------------------------------------
    slot_state_t       slot_tbl    [THREAD_SLOTS];
    logic [PEER_W-1:0] partner_tbl [THREAD_SLOTS];
    logic [LEN_W-1:0]  wlen_tbl    [THREAD_SLOTS];
    logic [IDX_W-1:0]  cur_slot;

    call_outcome_t pending_outcomes[$];
    call_outcome_t oldest_outcome;

    logic gaps_on       = 1'b1;  // random idling on both channels
    int   hold_requests = 0;     // bumped to ask the sink for a long hold
    int   hold_seen;
    int   sink_stall_left;
    int   quiet_cycles;
    int   mismatch_count = 0;
    int   calls_issued   = 0;
    int   outcomes_checked = 0;
    int   wakes_predicted  = 0;
    int   blocks_predicted = 0;
    int   refusals_predicted = 0;
    int   idle_predicted   = 0;

    function automatic void reset_thread_table();
        for (int i = 0; i < THREAD_SLOTS; i++) begin
            slot_tbl[i]    = ST_FREE;
            partner_tbl[i] = '0;
            wlen_tbl[i]    = '0;
        end
        slot_tbl[0] = ST_RUNNING;
        cur_slot    = '0;
    endfunction

    // Round robin from the slot after the current one; slot 0 never picked.
    // When nothing is ready the caller stays current.
    function automatic void advance_round_robin();
        logic [IDX_W-1:0] idx;
        for (int i = 1; i <= THREAD_SLOTS; i++) begin
            idx = cur_slot + i[IDX_W-1:0];
            if (idx != 0 && slot_tbl[idx] == ST_READY) begin
                if (slot_tbl[cur_slot] == ST_RUNNING)
                    slot_tbl[cur_slot] = ST_READY;
                slot_tbl[idx] = ST_RUNNING;
                cur_slot      = idx;
                return;
            end
        end
    endfunction

    function automatic logic peer_ok(logic [PEER_W-1:0] peer);
        return peer != {1'b0, cur_slot} && peer < THREAD_SLOTS && peer < PEER_LIMIT &&
               slot_tbl[peer[IDX_W-1:0]] != ST_FREE;
    endfunction

    function automatic void block_current(logic [PEER_W-1:0] partner, logic [LEN_W-1:0] len);
        slot_tbl[cur_slot]    = ST_BLOCKED;
        partner_tbl[cur_slot] = partner;
        wlen_tbl[cur_slot]    = len;
        advance_round_robin();
    endfunction

    // Applies one kernel call to the table and returns its outcome.
    function automatic call_outcome_t resolve_call(logic [OP_W-1:0] op,
                                                   logic [PEER_W-1:0] peer,
                                                   logic [LEN_W-1:0] len);
        call_outcome_t    r;
        logic [IDX_W-1:0] before_slot;
        logic [IDX_W-1:0] found;
        logic             hit;
        logic             running;
        r           = '0;
        r.status    = STAT_DONE;
        before_slot = cur_slot;
        running     = slot_tbl[cur_slot] == ST_RUNNING;
        hit         = 1'b0;
        found       = '0;
        if (op == OP_CREATE) begin
            r.status = STAT_ERROR;
            for (int i = 1; i < THREAD_SLOTS; i++) begin
                if (r.status == STAT_ERROR && slot_tbl[i] == ST_FREE) begin
                    slot_tbl[i] = ST_READY;
                    r.status    = STAT_DONE;
                    r.value     = 32'(i);
                end
            end
        end else if (op == OP_SCHED) begin
            advance_round_robin();
        end else if (op >= OP_EXIT && op <= OP_UART && !running) begin
            // caller is not running: refused, nothing changes
            r.status = STAT_ERROR;
        end else if (op == OP_EXIT) begin
            slot_tbl[cur_slot] = ST_FREE;
            advance_round_robin();
        end else if (op == OP_SEND) begin
            if (!peer_ok(peer)) begin
                r.status = STAT_ERROR;
            end else if (slot_tbl[peer[IDX_W-1:0]] == ST_BLOCKED &&
                         (partner_tbl[peer[IDX_W-1:0]] == {1'b0, cur_slot} ||
                          partner_tbl[peer[IDX_W-1:0]] == PARTNER_ANY)) begin
                hit   = 1'b1;
                found = peer[IDX_W-1:0];
            end else begin
                r.status = STAT_BLOCKED;
                block_current(peer, len);
            end
        end else if (op == OP_RECV) begin
            if (peer != PARTNER_ANY) begin
                if (!peer_ok(peer)) begin
                    r.status = STAT_ERROR;
                end else if (slot_tbl[peer[IDX_W-1:0]] == ST_BLOCKED &&
                             partner_tbl[peer[IDX_W-1:0]] == {1'b0, cur_slot}) begin
                    hit   = 1'b1;
                    found = peer[IDX_W-1:0];
                end
            end else begin
                // lowest sender from slot 1 that waits on the caller
                for (int i = 1; i < THREAD_SLOTS; i++) begin
                    if (!hit && slot_tbl[i] == ST_BLOCKED &&
                        partner_tbl[i] == {1'b0, cur_slot}) begin
                        hit   = 1'b1;
                        found = i[IDX_W-1:0];
                    end
                end
            end
            if (r.status == STAT_DONE && !hit) begin
                r.status = STAT_BLOCKED;
                block_current(peer, len);
            end
        end else if (op == OP_UART) begin
            r.status = STAT_BLOCKED;
            block_current(PARTNER_UART, len);
        end
        if (hit) begin
            r.value         = len < wlen_tbl[found] ? len : wlen_tbl[found];
            slot_tbl[found] = ST_READY;
            r.woken_valid   = 1'b1;
            r.woken_thread  = found;
        end
        r.running_thread = cur_slot;
        r.switched       = cur_slot != before_slot;
        r.idle           = slot_tbl[cur_slot] != ST_RUNNING;
        return r;
    endfunction

    // slots 1 and up in a given state (slot 0 never runs again once left)
    function automatic int count_slots(slot_state_t st);
        int n;
        n = 0;
        for (int i = 1; i < THREAD_SLOTS; i++)
            if (slot_tbl[i] == st) n++;
        return n;
    endfunction

    // ------------------------------------------------------------------
    // Driver: one call per item, prediction taken at acceptance
    // ------------------------------------------------------------------
    task automatic issue_call(logic [OP_W-1:0] op, logic [PEER_W-1:0] peer,
                              logic [LEN_W-1:0] len);
        call_outcome_t r;
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {len, peer, op};
        do @(posedge aclk); while (!s_tready);
        r = resolve_call(op, peer, len);
        pending_outcomes.push_back(r);
        calls_issued++;
        if (r.woken_valid) wakes_predicted++;
        if (r.status == STAT_BLOCKED) blocks_predicted++;
        if (r.status == STAT_ERROR) refusals_predicted++;
        if (r.idle) idle_predicted++;
    endtask

    // Sender pauses until every outstanding result has arrived.
    task automatic wait_all_results(int settle);
        s_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    function automatic logic [LEN_W-1:0] pick_length();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return '0;
        if (roll == 1) return '1;
        if (roll < 5) return LEN_W'($urandom_range(1, 4096));
        return $urandom;
    endfunction

    // Peers lean toward live slots and toward partners already waiting on
    // the caller, so rendezvous actually complete.
    function automatic logic [PEER_W-1:0] pick_peer(logic [OP_W-1:0] op);
        logic [PEER_W-1:0] live[$];
        logic [PEER_W-1:0] waiting[$];
        int roll;
        for (int i = 0; i < THREAD_SLOTS; i++) begin
            if (i != cur_slot && slot_tbl[i] != ST_FREE)
                live.push_back(PEER_W'(i));
            if (slot_tbl[i] == ST_BLOCKED && (partner_tbl[i] == {1'b0, cur_slot} ||
                (op == OP_SEND && partner_tbl[i] == PARTNER_ANY)))
                waiting.push_back(PEER_W'(i));
        end
        roll = $urandom_range(0, 99);
        if (roll < 45 && waiting.size() != 0)
            return waiting[$urandom_range(0, waiting.size() - 1)];
        if (roll < 60 && op == OP_RECV)
            return PARTNER_ANY;
        if (roll < 88 && live.size() != 0)
            return live[$urandom_range(0, live.size() - 1)];
        return PEER_W'($urandom_range(0, 31));
    endfunction

    task automatic issue_random_call();
        logic [OP_W-1:0] op;
        int roll;
        int uart_waiters;
        roll = $urandom_range(0, 99);
        if (roll < 14)      op = OP_CREATE;
        else if (roll < 22) op = OP_EXIT;
        else if (roll < 38) op = OP_SCHED;
        else if (roll < 64) op = OP_SEND;
        else if (roll < 90) op = OP_RECV;
        else if (roll < 95) op = OP_UART;
        else if (roll < 97) op = OP_UNUSED_6;
        else                op = OP_UNUSED_7;
        // idle table: mostly the calls that can bring a thread back
        if (slot_tbl[cur_slot] != ST_RUNNING && $urandom_range(0, 4) != 0)
            op = $urandom_range(0, 1) ? OP_CREATE : OP_SCHED;
        // uart waiters never wake, keep them from eating the table
        uart_waiters = 0;
        for (int i = 0; i < THREAD_SLOTS; i++)
            if (slot_tbl[i] == ST_BLOCKED && partner_tbl[i] == PARTNER_UART)
                uart_waiters++;
        if (op == OP_UART && uart_waiters >= 3)
            op = OP_SCHED;
        // last runnable thread with a full table must not block: that would
        // leave no way out
        if (count_slots(ST_FREE) == 0 && count_slots(ST_READY) == 0 &&
            (op == OP_SEND || op == OP_RECV || op == OP_UART))
            op = OP_EXIT;
        issue_call(op, pick_peer(op), pick_length());
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed_calls();
        issue_call(OP_SCHED, 5'd0, 32'd0);             // nothing ready after reset
        issue_call(OP_SEND, 5'd5, 32'd1);              // target slot is free
        issue_call(OP_RECV, 5'd0, 32'd1);              // caller names itself
        issue_call(OP_SEND, 5'd20, 32'd1);             // peer out of range
        issue_call(OP_SEND, PARTNER_ANY, 32'd1);       // any-thread is receive only
        repeat (3) issue_call(OP_CREATE, 5'd31, 32'hFFFF_FFFF);  // slots 1..3
        issue_call(OP_UNUSED_6, 5'd31, 32'hFFFF_FFFF); // unknown codes: no-op
        issue_call(OP_UNUSED_7, 5'd0, 32'd0);
        issue_call(OP_SEND, 5'd1, 32'h0000_1000);      // 0 blocks on 1, 1 runs
        issue_call(OP_RECV, 5'd0, 32'hFFFF_FFFF);      // named receive wakes 0
        issue_call(OP_RECV, 5'd2, 32'd0);              // 1 waits on 2, 2 runs
        issue_call(OP_SEND, 5'd1, 32'hFFFF_FFFF);      // wakes 1, min size is zero
        issue_call(OP_UART, 5'd0, 32'd64);             // 2 parks on uart, 3 runs
        issue_call(OP_SEND, 5'd2, 32'd8);              // uart waiter not woken
        issue_call(OP_RECV, PARTNER_ANY, 32'd16);      // no sender, nothing ready
        issue_call(OP_EXIT, 5'd0, 32'd0);              // refused while idle
        issue_call(OP_UART, 5'd0, 32'd0);              // refused while idle
        issue_call(OP_SCHED, 5'd0, 32'd0);             // rescan, still idle
        issue_call(OP_CREATE, 5'd0, 32'd0);            // create works while idle
        issue_call(OP_SCHED, 5'd0, 32'd0);             // new thread runs
        issue_call(OP_SEND, 5'd1, 32'd3);              // matches an any-thread waiter
        issue_call(OP_EXIT, 5'd0, 32'd0);              // frees caller, next one runs
        wait_all_results(2);
    endtask

    // Fill the table while the sink holds off for a long stretch, so the
    // block's output and sequencer both fill and s_tready drops.
    task automatic test_table_full_under_backpressure();
        hold_requests <= hold_requests + 1;
        while (count_slots(ST_FREE) != 0)
            issue_call(OP_CREATE, PEER_W'($urandom), pick_length());
        issue_call(OP_CREATE, PEER_W'($urandom), pick_length());  // no free slot
        repeat (4) issue_call(OP_SCHED, PEER_W'($urandom), $urandom);
        wait_all_results(2);
    endtask

    task automatic test_random_traffic(int n);
        repeat (n) issue_random_call();
        wait_all_results(2);
    endtask

    task automatic test_streaming_no_idle(int n);
        gaps_on <= 1'b0;
        wait_all_results(2);
        repeat (n) issue_random_call();
    endtask

    // ------------------------------------------------------------------
    // Sink: random stall bursts, plus the requested hold
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready        <= 1'b0;
            sink_stall_left <= 0;
            hold_seen       <= 0;
        end else if (hold_seen != hold_requests) begin
            hold_seen       <= hold_requests;
            sink_stall_left <= HOLD_CYCLES;
            m_tready        <= 1'b0;
        end else if (sink_stall_left != 0) begin
            sink_stall_left <= sink_stall_left - 1;
            m_tready        <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 7) == 0) begin
            sink_stall_left <= $urandom_range(0, 15);
            m_tready        <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Checker: each result against the oldest prediction
    // ------------------------------------------------------------------
    task automatic compare_outcome_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_outcomes.size() == 0) begin
                $display("%0t ns: result item expected none, actual %h", $time, m_tdata);
                mismatch_count++;
            end else begin
                oldest_outcome = pending_outcomes.pop_front();
                compare_outcome_field("status", 32'(oldest_outcome.status), 32'(m_tdata[1:0]));
                compare_outcome_field("result_value", oldest_outcome.value, m_tdata[33:2]);
                compare_outcome_field("woken_valid", 32'(oldest_outcome.woken_valid),
                                      32'(m_tdata[34]));
                compare_outcome_field("woken_thread", 32'(oldest_outcome.woken_thread),
                                      32'(m_tdata[38:35]));
                compare_outcome_field("running_thread", 32'(oldest_outcome.running_thread),
                                      32'(m_tdata[42:39]));
                compare_outcome_field("switched", 32'(oldest_outcome.switched),
                                      32'(m_tdata[43]));
                compare_outcome_field("idle", 32'(oldest_outcome.idle), 32'(m_tdata[44]));
                compare_outcome_field("pad", 32'(oldest_outcome.pad), 32'(m_tdata[47:45]));
            end
            outcomes_checked++;
        end
    end

    // Watchdog: no item moving on either channel for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("%0t ns: watchdog, no item accepted in %0d cycles", $time, quiet_cycles);
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        reset_thread_table();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_calls();
        test_table_full_under_backpressure();
        test_random_traffic(330);
        test_streaming_no_idle(60);
        wait_all_results(END_SETTLE);
        $display("Covered %0d calls, %0d results: %0d wakes, %0d blocks, %0d refusals,",
                 calls_issued, outcomes_checked, wakes_predicted, blocks_predicted,
                 refusals_predicted);
        $display("  %0d idle results, one long output hold, idling on both channels.",
                 idle_predicted);
        if (mismatch_count == 0 && pending_outcomes.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
